### hdl/lens_flare_pixel_overlay_macros.svh
// ---------------------------------------------------------------------------
// Lens flare overlay assertion macros
// Concurrent check wrappers; defining ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef LENS_FLARE_PIXEL_OVERLAY_MACROS_SVH
`define LENS_FLARE_PIXEL_OVERLAY_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LFO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lens flare overlay: check failed");
// next-cycle implication
`define LFO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lens flare overlay: check failed");
`else
`define LFO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LFO_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/lfo_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lens flare overlay package
// Register map, fixed-point constants and the 2^-x table.
// ---------------------------------------------------------------------------
package lfo_pkg;

  typedef enum logic [2:0] {
    REG_SUN_X_FRAC   = 3'd0,
    REG_SUN_Y_FRAC   = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_GLOW_SCALE   = 3'd4,
    REG_OPACITY      = 3'd5,
    REG_TINT_COLOR   = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] RST_SUN_X_FRAC   = 16'd13107;
  localparam logic [15:0] RST_SUN_Y_FRAC   = 16'd13107;
  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd512;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd512;
  localparam logic [11:0] RST_GLOW_SCALE   = 12'd256;
  localparam logic [8:0]  RST_OPACITY      = 9'd154;
  localparam logic [23:0] RST_TINT_COLOR   = 24'd16770739;

  // radii in Q16 pixels per Q4.8 scale unit (200, 120, 30 times 256)
  localparam logic [15:0] GLOW_R_K  = 16'd51200;
  localparam logic [14:0] HALO_RH_K = 15'd30720;
  localparam logic [12:0] HALO_S_K  = 13'd7680;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] MASK_ONE  = 17'd65536;

  // quotient bits; halo ratio at or above 16.0 means no halo
  localparam int QUO_W = 20;

  function automatic logic [16:0] exp2_frac(input logic [4:0] k);
    logic [16:0] val;
    case (k)
      5'd0:    val = 17'd65536;
      5'd1:    val = 17'd62757;
      5'd2:    val = 17'd60097;
      5'd3:    val = 17'd57549;
      5'd4:    val = 17'd55109;
      5'd5:    val = 17'd52773;
      5'd6:    val = 17'd50535;
      5'd7:    val = 17'd48393;
      5'd8:    val = 17'd46341;
      5'd9:    val = 17'd44376;
      5'd10:   val = 17'd42495;
      5'd11:   val = 17'd40693;
      5'd12:   val = 17'd38968;
      5'd13:   val = 17'd37316;
      5'd14:   val = 17'd35734;
      5'd15:   val = 17'd34219;
      default: val = 17'd32768;
    endcase
    return val;
  endfunction

endpackage

### hdl/lfo_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage, RW stages.
// ---------------------------------------------------------------------------
module lfo_isqrt #(
  parameter int RW = 30
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int SW = 2 * RW;

  logic [SW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_bit
    localparam int B = RW - 1 - i;
    logic [SW-1:0] rem_in;
    logic [SW-1:0] trial;
    logic [RW-1:0] root_in;

    if (i == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (SW'(root_in) << (B + 1)) + (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

### hdl/lfo_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// QW quotient bits, one per stage; ovf flags a quotient of 2^QW or more.
// ---------------------------------------------------------------------------
module lfo_div #(
  parameter int NW = 44,
  parameter int DW = 30,
  parameter int QW = 20
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int CW = (NW > DW) ? NW : DW;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_bit
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic          ovf_in;
    logic [DW:0]   trial;

    if (i == 0) begin : g_first
      assign ovf_in = CW'(num >> QW) >= CW'(den);
      assign rem_in = ovf_in ? '0 : DW'(num >> QW);
      assign den_in = den;
      assign lo_in  = num[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign ovf_in = ovf_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign trial = {rem_in, lo_in[QW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[i] <= ovf_in;
        den_q[i] <= den_in;
        lo_q[i]  <= lo_in << 1;
        if (trial >= {1'b0, den_in}) begin
          rem_q[i] <= DW'(trial - {1'b0, den_in});
          quo_q[i] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_q[i] <= DW'(trial);
          quo_q[i] <= {quo_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[QW-1];
  assign ovf = ovf_q[QW-1];

endmodule

### hdl/lens_flare_pixel_overlay.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lens flare pixel overlay
// Adds a sun glow and a reflected halo to a stream of RGB pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Pixel channel (pix_valid / pix_stall) carries pixel_x, pixel_y and the
//   three color channels; result channel (flare_valid / flare_stall) carries
//   red_out, green_out, blue_out. A beat moves when valid is high and stall
//   is low. One result beat per pixel beat, in order.
//   Throughput: one pixel per clock while the output is not stalled. RT_W
//   is the square-root width (30 at MAX_DIM = 4096). Depth is set by the
//   two bit-per-stage square roots and the 20-stage dividers.
//   The cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes one
//   register per beat; it is always ready. Write only while no pixel is in
//   flight; derived sun and radius terms settle in the cycle after a write.
//   Reset (rst, synchronous) clears all valid bits and loads the register
//   defaults. When the receiver stalls a valid result, the whole pipeline
//   holds and pix_stall rises; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "lens_flare_pixel_overlay_macros.svh"

module lens_flare_pixel_overlay #(
  parameter int MAX_DIM      = 4096,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // pixel channel
  input  logic                    pix_valid,
  output logic                    pix_stall,
  input  logic [11:0]             pixel_x,
  input  logic [11:0]             pixel_y,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  // result channel
  output logic                    flare_valid,
  input  logic                    flare_stall,
  output logic [CHANNEL_BITS-1:0] red_out,
  output logic [CHANNEL_BITS-1:0] green_out,
  output logic [CHANNEL_BITS-1:0] blue_out,
  // register write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [23:0]             cfg_data
);

  localparam int CB     = CHANNEL_BITS;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = (16 + DIM_W > 28) ? 16 + DIM_W : 28;  // Q16 positions
  localparam int RT_W   = POS_W + 1;                             // distance width
  localparam int SQ_W   = 2 * RT_W;
  localparam int QW     = lfo_pkg::QUO_W;
  localparam int SIDE_W = 1 + 3 * CB;                            // valid + rgb
  localparam int TAIL   = 8;
  localparam int RND_SH = 32 - CB;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  logic [15:0] sun_x_frac;
  logic [15:0] sun_y_frac;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [11:0] glow_scale;
  logic [8:0]  opacity;
  logic [23:0] tint_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_x_frac   <= lfo_pkg::RST_SUN_X_FRAC;
      sun_y_frac   <= lfo_pkg::RST_SUN_Y_FRAC;
      image_width  <= lfo_pkg::RST_IMAGE_WIDTH;
      image_height <= lfo_pkg::RST_IMAGE_HEIGHT;
      glow_scale   <= lfo_pkg::RST_GLOW_SCALE;
      opacity      <= lfo_pkg::RST_OPACITY;
      tint_color   <= lfo_pkg::RST_TINT_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lfo_pkg::cfg_reg_t'(cfg_index))
        lfo_pkg::REG_SUN_X_FRAC:   sun_x_frac   <= cfg_data[15:0];
        lfo_pkg::REG_SUN_Y_FRAC:   sun_y_frac   <= cfg_data[15:0];
        lfo_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        lfo_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        lfo_pkg::REG_GLOW_SCALE:   glow_scale   <= cfg_data[11:0];
        lfo_pkg::REG_OPACITY:      opacity      <= cfg_data[8:0];
        lfo_pkg::REG_TINT_COLOR:   tint_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Derived terms: sun, reflected sun (W-sx = W*(1-fx)), radii; registered.
  // -------------------------------------------------------------------------
  logic [DIM_W-1:0] w_clamp;
  logic [DIM_W-1:0] h_clamp;
  logic [POS_W-1:0] sun_x;
  logic [POS_W-1:0] sun_y;
  logic [POS_W-1:0] ref_x;
  logic [POS_W-1:0] ref_y;
  logic [27:0]      glow_r;
  logic [26:0]      halo_rh;
  logic [24:0]      halo_s;

  assign w_clamp = (32'(image_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_width);
  assign h_clamp = (32'(image_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_height);

  always_ff @(posedge clk) begin
    sun_x   <= POS_W'(sun_x_frac) * POS_W'(w_clamp);
    sun_y   <= POS_W'(sun_y_frac) * POS_W'(h_clamp);
    ref_x   <= POS_W'(17'h10000 - {1'b0, sun_x_frac}) * POS_W'(w_clamp);
    ref_y   <= POS_W'(17'h10000 - {1'b0, sun_y_frac}) * POS_W'(h_clamp);
    glow_r  <= 28'(glow_scale) * 28'(lfo_pkg::GLOW_R_K);
    halo_rh <= 27'(glow_scale) * 27'(lfo_pkg::HALO_RH_K);
    halo_s  <= 25'(glow_scale) * 25'(lfo_pkg::HALO_S_K);
  end

  // -------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless the output is held.
  // -------------------------------------------------------------------------
  logic pipe_en;

  assign pipe_en   = !(flare_valid && flare_stall);
  assign pix_stall = !pipe_en;

  function automatic logic [POS_W-1:0] abs_diff(input logic [11:0] p,
                                                input logic [POS_W-1:0] c);
    logic signed [POS_W:0] dif;
    dif = $signed({1'b0, POS_W'({p, 16'b0})}) - $signed({1'b0, c});
    return dif[POS_W] ? POS_W'(-dif) : POS_W'(dif);
  endfunction

  // S0: input capture
  logic [SIDE_W-1:0] s0_side;
  logic [11:0]       s0_px;
  logic [11:0]       s0_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side <= '0;
    end else if (pipe_en) begin
      s0_side <= {pix_valid, red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_px <= pixel_x;
      s0_py <= pixel_y;
    end
  end

  // S1: offsets to sun and reflected sun
  logic [SIDE_W-1:0] s1_side;
  logic [POS_W-1:0]  s1_ax, s1_ay, s1_hx, s1_hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else if (pipe_en) begin
      s1_side <= s0_side;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_ax <= abs_diff(s0_px, sun_x);
      s1_ay <= abs_diff(s0_py, sun_y);
      s1_hx <= abs_diff(s0_px, ref_x);
      s1_hy <= abs_diff(s0_py, ref_y);
    end
  end

  // S2: squares
  logic [SIDE_W-1:0]  s2_side;
  logic [2*POS_W-1:0] s2_ax2, s2_ay2, s2_hx2, s2_hy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side <= '0;
    end else if (pipe_en) begin
      s2_side <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_ax2 <= (2*POS_W)'(s1_ax) * (2*POS_W)'(s1_ax);
      s2_ay2 <= (2*POS_W)'(s1_ay) * (2*POS_W)'(s1_ay);
      s2_hx2 <= (2*POS_W)'(s1_hx) * (2*POS_W)'(s1_hx);
      s2_hy2 <= (2*POS_W)'(s1_hy) * (2*POS_W)'(s1_hy);
    end
  end

  // S3: sums of squares
  logic [SIDE_W-1:0] s3_side;
  logic [SQ_W-1:0]   s3_d2, s3_h2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side <= '0;
    end else if (pipe_en) begin
      s3_side <= s2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_d2 <= SQ_W'(s2_ax2) + SQ_W'(s2_ay2);
      s3_h2 <= SQ_W'(s2_hx2) + SQ_W'(s2_hy2);
    end
  end

  // Square roots, RT_W stages
  logic [RT_W-1:0]   dist_sun;
  logic [RT_W-1:0]   dist_halo;
  logic [SIDE_W-1:0] sq_line [RT_W];

  lfo_isqrt #(.RW(RT_W)) u_sqrt_sun (
    .clk  (clk),
    .en   (pipe_en),
    .rad  (s3_d2),
    .root (dist_sun)
  );

  lfo_isqrt #(.RW(RT_W)) u_sqrt_halo (
    .clk  (clk),
    .en   (pipe_en),
    .rad  (s3_h2),
    .root (dist_halo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RT_W; i++) sq_line[i] <= '0;
    end else if (pipe_en) begin
      sq_line[0] <= s3_side;
      for (int i = 1; i < RT_W; i++) sq_line[i] <= sq_line[i-1];
    end
  end

  // PD: glow denominator d+r and halo offset |dh-rh|
  logic [SIDE_W-1:0] pd_side;
  logic [RT_W:0]     pd_den;
  logic [RT_W-1:0]   pd_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_side <= '0;
    end else if (pipe_en) begin
      pd_side <= sq_line[RT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pd_den <= (RT_W+1)'(dist_sun) + (RT_W+1)'(glow_r);
      pd_e   <= (dist_halo > RT_W'(halo_rh)) ? dist_halo - RT_W'(halo_rh)
                                              : RT_W'(halo_rh) - dist_halo;
    end
  end

  // Dividers, QW stages
  logic [QW-1:0]     glow_q;
  logic              glow_ovf;
  logic [QW-1:0]     halo_q;
  logic              halo_ovf;
  logic [SIDE_W-1:0] dv_line [QW];

  lfo_div #(.NW(44), .DW(RT_W + 1), .QW(QW)) u_div_glow (
    .clk (clk),
    .en  (pipe_en),
    .num ({glow_r, 16'b0}),
    .den (pd_den),
    .quo (glow_q),
    .ovf (glow_ovf)
  );

  lfo_div #(.NW(RT_W + 16), .DW(25), .QW(QW)) u_div_halo (
    .clk (clk),
    .en  (pipe_en),
    .num ({pd_e, 16'b0}),
    .den (halo_s),
    .quo (halo_q),
    .ovf (halo_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) dv_line[i] <= '0;
    end else if (pipe_en) begin
      dv_line[0] <= pd_side;
      for (int i = 1; i < QW; i++) dv_line[i] <= dv_line[i-1];
    end
  end

  // Tail side line: entry i lines up with stage P(i+1)
  logic [SIDE_W-1:0] tail [TAIL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAIL; i++) tail[i] <= '0;
    end else if (pipe_en) begin
      tail[0] <= dv_line[QW-1];
      for (int i = 1; i < TAIL; i++) tail[i] <= tail[i-1];
    end
  end

  // P1: first glow squaring, halo ratio squared
  logic [2*QW-1:0] p1_t2;
  logic [2*QW-1:0] p1_qq;
  logic            p1_glow_ovf;
  logic            p1_hok;

  // P2: rounding
  logic [16:0] p2_g1;
  logic [22:0] p2_u;
  logic        p2_hok;

  // P3: second glow squaring, u * log2(e)
  logic [33:0] p3_g1sq;
  logic [39:0] p3_uv;
  logic        p3_hok;

  // P4: glow done, table lookup
  logic [16:0] p4_glow;
  logic [16:0] p4_a;
  logic [11:0] p4_dif;
  logic [11:0] p4_fr;
  logic [4:0]  p4_n;
  logic        p4_hok;

  logic [23:0] v_c;
  logic [4:0]  k_c;

  // P5: interpolation product
  logic [16:0] p5_glow;
  logic [16:0] p5_a;
  logic [23:0] p5_prod;
  logic [4:0]  p5_n;
  logic        p5_hok;

  // P6: mask
  logic [16:0] p6_mask;
  logic [16:0] m_c;
  logic [16:0] halo_c;
  logic [17:0] sum_c;

  // P7, P8: channel gain
  logic [24:0] p7_mr, p7_mg, p7_mb;
  logic [33:0] p8_ar, p8_ag, p8_ab;

  assign v_c    = 24'((p3_uv + 40'd32768) >> 16);
  assign k_c    = {1'b0, v_c[15:12]};
  assign m_c    = p5_a - 17'((25'(p5_prod) + 25'd2048) >> 12);
  assign halo_c = p5_hok ? ((m_c >> p5_n) >> 1) : 17'd0;
  assign sum_c  = 18'(p5_glow) + 18'(halo_c);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_t2       <= (2*QW)'(glow_q) * (2*QW)'(glow_q);
      p1_qq       <= (2*QW)'(halo_q) * (2*QW)'(halo_q);
      p1_glow_ovf <= glow_ovf;
      p1_hok      <= !halo_ovf;

      p2_g1  <= 17'((p1_t2 + (2*QW)'(32768)) >> 16);
      p2_u   <= 23'((p1_qq + (2*QW)'(65536)) >> 17);
      p2_hok <= p1_hok;

      p3_g1sq <= 34'(p2_g1) * 34'(p2_g1);
      p3_uv   <= 40'(p2_u) * 40'(lfo_pkg::LOG2E_Q16);
      p3_hok  <= p2_hok;

      p4_glow <= 17'((p3_g1sq + 34'd32768) >> 16);
      p4_a    <= lfo_pkg::exp2_frac(k_c);
      p4_dif  <= 12'(lfo_pkg::exp2_frac(k_c) - lfo_pkg::exp2_frac(k_c + 5'd1));
      p4_fr   <= v_c[11:0];
      p4_n    <= v_c[20:16];
      p4_hok  <= p3_hok && (v_c[23:16] < 8'd17);

      p5_glow <= p4_glow;
      p5_a    <= p4_a;
      p5_prod <= 24'(p4_dif) * 24'(p4_fr);
      p5_n    <= p4_n;
      p5_hok  <= p4_hok;

      if (glow_scale == 12'd0) begin
        p6_mask <= 17'd0;
      end else if (sum_c > 18'(lfo_pkg::MASK_ONE)) begin
        p6_mask <= lfo_pkg::MASK_ONE;
      end else begin
        p6_mask <= 17'(sum_c);
      end

      p7_mr <= 25'(p6_mask) * 25'(tint_color[23:16]);
      p7_mg <= 25'(p6_mask) * 25'(tint_color[15:8]);
      p7_mb <= 25'(p6_mask) * 25'(tint_color[7:0]);

      p8_ar <= 34'(p7_mr) * 34'(opacity);
      p8_ag <= 34'(p7_mg) * 34'(opacity);
      p8_ab <= 34'(p7_mb) * 34'(opacity);
    end
  end

  // Output: round, add, saturate
  function automatic logic [CB-1:0] blend(input logic [CB-1:0] pix,
                                          input logic [33:0] gain);
    logic [34:0] add;
    logic [34:0] sum;
    add = (35'(gain) + (35'(1) << (RND_SH - 1))) >> RND_SH;
    sum = 35'(pix) + add;
    return (sum > 35'(CMAX)) ? CMAX : CB'(sum);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      flare_valid <= 1'b0;
    end else if (pipe_en) begin
      flare_valid <= tail[TAIL-1][SIDE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      red_out   <= blend(tail[TAIL-1][3*CB-1:2*CB], p8_ar);
      green_out <= blend(tail[TAIL-1][2*CB-1:CB], p8_ag);
      blue_out  <= blend(tail[TAIL-1][CB-1:0], p8_ab);
    end
  end

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `LFO_ASSERT_NXT(a_accept_enters, clk, rst, pix_valid && !pix_stall, s0_side[SIDE_W-1])
  `LFO_ASSERT_NXT(a_hold_freezes, clk, rst, !pipe_en, $stable(sq_line[0]) && $stable(tail[0]))
  `LFO_ASSERT_IMP(a_glow_ratio, clk, rst, tail[0][SIDE_W-1] && !p1_glow_ovf, p1_t2 <= 40'h1_0000_0000)
  `LFO_ASSERT_IMP(a_mask_bound, clk, rst, tail[5][SIDE_W-1], p6_mask <= lfo_pkg::MASK_ONE)

endmodule
